// ===== rtl/cie94_pkg.sv =====
// shared constants, types and codes for the cie94 colour difference block
`default_nettype none

package cie94_pkg;

	// fixed-point formats
	localparam int FRACTION_BITS = 8;
	localparam int CHROMA_FRAC   = 15;
	localparam int WEIGHT_FRAC   = 26;
	localparam int SUM_FRAC      = 14;
	localparam int PROD_SHIFT    = CHROMA_FRAC + WEIGHT_FRAC - SUM_FRAC;

	// weighting numerator: 1000 scaled to chroma units, and the divider dividend
	localparam logic [63:0] WEIGHT_TOP = 64'd1000 << (FRACTION_BITS + CHROMA_FRAC);
	localparam logic [63:0] WEIGHT_NUM = WEIGHT_TOP << WEIGHT_FRAC;
	localparam int          DEN_W      = 39;

	// pipeline geometry
	localparam int SQRT_STAGES = 32;
	localparam int BACK_DEPTH  = 3 * SQRT_STAGES + 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// result limit
	localparam logic [16:0] DIFF_MAX = 17'h1FFFF;

	// register index of the weighting mode
	localparam logic REG_MODE = 1'b0;

	// weighting constants in thousandths
	localparam logic [5:0] KC_GRAPHIC = 6'd45;
	localparam logic [5:0] KC_TEXTILE = 6'd48;
	localparam logic [5:0] KH_GRAPHIC = 6'd15;
	localparam logic [5:0] KH_TEXTILE = 6'd14;

	typedef enum logic {
		MODE_GRAPHIC = 1'b0,
		MODE_TEXTILE = 1'b1
	} mode_t;

	// one classified request as held in the queue
	typedef struct packed {
		mode_t       mode;
		logic [15:0] mag_a1;
		logic [15:0] mag_b1;
		logic [15:0] mag_a2;
		logic [15:0] mag_b2;
		logic [15:0] mag_da;
		logic [15:0] mag_db;
		logic [14:0] mag_dl;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/cie94_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none

module cie94_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	import cie94_pkg::*;

	logic [63:0] rem_q [SQRT_STAGES];
	logic [31:0] res_q [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		localparam int B = SQRT_STAGES - 1 - g;
		logic [63:0] rem_in;
		logic [31:0] res_in;
		logic [65:0] trial;

		// stage input: the radicand or the previous stage
		if (g == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[g-1];
			assign res_in = res_q[g-1];
		end

		// growth of the square when this bit is set
		assign trial = ({34'd0, res_in} << (B + 1)) + (66'd1 << (2 * B));

		// keep the bit if the square still fits
		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rem_in} >= trial) begin
					rem_q[g] <= rem_in - trial[63:0];
					res_q[g] <= res_in | (32'd1 << B);
				end else begin
					rem_q[g] <= rem_in;
					res_q[g] <= res_in;
				end
			end
		end
	end

	assign root = res_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/cie94_div.sv =====
// pipelined restoring divider for the chroma weights, one quotient bit per stage
`default_nettype none

module cie94_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [cie94_pkg::DEN_W-1:0] den,
	output logic [31:0]               quo
);
	import cie94_pkg::*;

	logic [63:0]      rem_q [SQRT_STAGES];
	logic [31:0]      quo_q [SQRT_STAGES];
	logic [DEN_W-1:0] den_q [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		localparam int B = SQRT_STAGES - 1 - g;
		logic [63:0]      rem_in;
		logic [31:0]      quo_in;
		logic [DEN_W-1:0] den_in;
		logic [71:0]      sh;

		// stage input: the constant dividend or the previous stage
		if (g == 0) begin : g_first
			assign rem_in = WEIGHT_NUM;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[g-1];
			assign quo_in = quo_q[g-1];
			assign den_in = den_q[g-1];
		end

		assign sh = {{(72-DEN_W){1'b0}}, den_in} << B;

		// subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[g] <= den_in;
				if ({8'd0, rem_in} >= sh) begin
					rem_q[g] <= rem_in - sh[63:0];
					quo_q[g] <= quo_in | (32'd1 << B);
				end else begin
					rem_q[g] <= rem_in;
					quo_q[g] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/cie94_front.sv =====
// front end: takes requests, forms magnitudes and differences, queues them
`default_nettype none

module cie94_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cie94_pkg::mode_t    mode,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  logic [14:0]         first_lightness,
	input  logic signed [15:0]  first_green_red,
	input  logic signed [15:0]  first_blue_yellow,
	input  logic [14:0]         second_lightness,
	input  logic signed [15:0]  second_green_red,
	input  logic signed [15:0]  second_blue_yellow,
	input  logic                pop,
	output logic                head_valid,
	output cie94_pkg::item_t    head
);
	import cie94_pkg::*;

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

	function automatic logic [15:0] mag17(input logic signed [16:0] v);
		logic [16:0] n;
		n = 17'(-v);
		return v[16] ? n[15:0] : v[15:0];
	endfunction

	item_t                item;
	logic signed [16:0]   diff_a;
	logic signed [16:0]   diff_b;
	item_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;
	logic                 push;

	// classify: magnitudes and differences of the two colours
	assign diff_a = {first_green_red[15], first_green_red}
		- {second_green_red[15], second_green_red};
	assign diff_b = {first_blue_yellow[15], first_blue_yellow}
		- {second_blue_yellow[15], second_blue_yellow};

	always_comb begin
		item.mode   = mode;
		item.mag_a1 = mag16(first_green_red);
		item.mag_b1 = mag16(first_blue_yellow);
		item.mag_a2 = mag16(second_green_red);
		item.mag_b2 = mag16(second_blue_yellow);
		item.mag_da = mag17(diff_a);
		item.mag_db = mag17(diff_b);
		item.mag_dl = (first_lightness >= second_lightness)
			? first_lightness - second_lightness
			: second_lightness - first_lightness;
	end

	// queue handshake
	assign pair_stall = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push       = pair_valid && !pair_stall;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cie94_back.sv =====
// back end: chromas, hue difference, weights and the final root, fully pipelined
`default_nettype none

module cie94_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  cie94_pkg::item_t head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [16:0]      difference,
	output logic             saturated
);
	import cie94_pkg::*;

	typedef struct packed {
		mode_t       mode;
		logic [14:0] dl;
		logic [32:0] dab;
	} side_a_t;

	typedef struct packed {
		mode_t       mode;
		logic [14:0] dl;
		logic [30:0] dc;
	} side_b_t;

	logic                  adv;
	logic [BACK_DEPTH-1:0] vld_q;
	logic                  result_valid_q;
	logic [16:0]           difference_q;
	logic                  saturated_q;

	// stage 1
	logic [31:0] sq_a1, sq_b1, sq_a2, sq_b2, sq_da, sq_db;
	logic [31:0] ca1_s1, ca2_s1;
	logic [32:0] dab_s1;
	logic [14:0] dl_s1;
	mode_t       mode_s1;

	// chroma roots and first side line
	logic [31:0] r1, r2;
	side_a_t     side_a_q [SQRT_STAGES];
	side_a_t     side_a;

	// stages 2 to 4
	logic [30:0] dc_s2, r1_s2;
	logic [63:0] whole_s2;
	logic [14:0] dl_s2;
	mode_t       mode_s2;
	logic [5:0]  kc, kh;
	logic [61:0] dc2_w;
	logic [36:0] pc_w, ph_w;
	logic [61:0] dc2_s3;
	logic [36:0] pc_s3, ph_s3;
	logic [63:0] whole_s3;
	logic [30:0] dc_s3;
	logic [14:0] dl_s3;
	mode_t       mode_s3;
	logic [63:0] rad_s4;
	logic [DEN_W-1:0] denc_s4, denh_s4;
	logic [30:0] dc_s4;
	logic [14:0] dl_s4;
	mode_t       mode_s4;

	// hue root, weights and second side line
	logic [31:0] dh, wc, wh;
	side_b_t     side_b_q [SQRT_STAGES];
	side_b_t     side_b;

	// stages 5 to 7
	logic [57:0] yp_w;
	logic [58:0] zp_w;
	logic [57:0] yp_s5;
	logic [58:0] zp_s5;
	logic [28:0] x_s5;
	logic [30:0] y_w;
	logic [31:0] z_w;
	logic [57:0] xs_w;
	logic [61:0] ys_w;
	logic [63:0] zs_w;
	logic [57:0] xs_s6;
	logic [61:0] ys_s6;
	logic [63:0] zs_s6;
	logic [63:0] sum_s7;

	// final root and rounding
	logic [31:0] root;
	logic [32:0] rnd_w;
	logic [18:0] res_w;

	// the whole pipe moves unless a finished result is held
	assign adv = !result_valid_q || !result_stall;
	assign pop = adv && head_valid;

	// stage 1: squares of the magnitudes
	assign sq_a1 = head.mag_a1 * head.mag_a1;
	assign sq_b1 = head.mag_b1 * head.mag_b1;
	assign sq_a2 = head.mag_a2 * head.mag_a2;
	assign sq_b2 = head.mag_b2 * head.mag_b2;
	assign sq_da = head.mag_da * head.mag_da;
	assign sq_db = head.mag_db * head.mag_db;

	always_ff @(posedge clk) begin
		if (adv) begin
			ca1_s1  <= sq_a1 + sq_b1;
			ca2_s1  <= sq_a2 + sq_b2;
			dab_s1  <= {1'b0, sq_da} + {1'b0, sq_db};
			dl_s1   <= head.mag_dl;
			mode_s1 <= head.mode;
		end
	end

	// chroma of both colours
	cie94_sqrt u_sqrt_c1 (
		.clk  (clk),
		.en   (adv),
		.rad  (64'(ca1_s1) << (2 * CHROMA_FRAC)),
		.root (r1)
	);

	cie94_sqrt u_sqrt_c2 (
		.clk  (clk),
		.en   (adv),
		.rad  (64'(ca2_s1) << (2 * CHROMA_FRAC)),
		.root (r2)
	);

	// side data beside the chroma roots
	always_ff @(posedge clk) begin
		if (adv) begin
			side_a_q[0] <= '{mode: mode_s1, dl: dl_s1, dab: dab_s1};
			for (int k = 1; k < SQRT_STAGES; k++) begin
				side_a_q[k] <= side_a_q[k-1];
			end
		end
	end
	assign side_a = side_a_q[SQRT_STAGES-1];

	// stage 2: chroma difference and full radicand
	always_ff @(posedge clk) begin
		if (adv) begin
			dc_s2    <= (r1 >= r2) ? 31'(r1 - r2) : 31'(r2 - r1);
			r1_s2    <= r1[30:0];
			whole_s2 <= 64'(side_a.dab) << (2 * CHROMA_FRAC);
			dl_s2    <= side_a.dl;
			mode_s2  <= side_a.mode;
		end
	end

	// stage 3: chroma difference squared and weight products
	assign kc    = (mode_s2 == MODE_TEXTILE) ? KC_TEXTILE : KC_GRAPHIC;
	assign kh    = (mode_s2 == MODE_TEXTILE) ? KH_TEXTILE : KH_GRAPHIC;
	assign dc2_w = dc_s2 * dc_s2;
	assign pc_w  = kc * r1_s2;
	assign ph_w  = kh * r1_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dc2_s3   <= dc2_w;
			pc_s3    <= pc_w;
			ph_s3    <= ph_w;
			whole_s3 <= whole_s2;
			dc_s3    <= dc_s2;
			dl_s3    <= dl_s2;
			mode_s3  <= mode_s2;
		end
	end

	// stage 4: clamped hue radicand and weight divisors
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4  <= (whole_s3 > {2'b00, dc2_s3}) ? whole_s3 - {2'b00, dc2_s3} : '0;
			denc_s4 <= DEN_W'(WEIGHT_TOP) + {{(DEN_W-37){1'b0}}, pc_s3};
			denh_s4 <= DEN_W'(WEIGHT_TOP) + {{(DEN_W-37){1'b0}}, ph_s3};
			dc_s4   <= dc_s3;
			dl_s4   <= dl_s3;
			mode_s4 <= mode_s3;
		end
	end

	// hue difference and the two weights side by side
	cie94_sqrt u_sqrt_h (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s4),
		.root (dh)
	);

	cie94_div u_div_c (
		.clk (clk),
		.en  (adv),
		.den (denc_s4),
		.quo (wc)
	);

	cie94_div u_div_h (
		.clk (clk),
		.en  (adv),
		.den (denh_s4),
		.quo (wh)
	);

	// side data beside the hue root
	always_ff @(posedge clk) begin
		if (adv) begin
			side_b_q[0] <= '{mode: mode_s4, dl: dl_s4, dc: dc_s4};
			for (int k = 1; k < SQRT_STAGES; k++) begin
				side_b_q[k] <= side_b_q[k-1];
			end
		end
	end
	assign side_b = side_b_q[SQRT_STAGES-1];

	// stage 5: weighted chroma and hue terms, scaled lightness
	assign yp_w = side_b.dc * wc[26:0];
	assign zp_w = dh * wh[26:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			yp_s5 <= yp_w;
			zp_s5 <= zp_w;
			x_s5  <= (side_b.mode == MODE_TEXTILE)
				? 29'(side_b.dl) << (SUM_FRAC - 1)
				: 29'(side_b.dl) << SUM_FRAC;
		end
	end

	// stage 6: squares of the three terms
	assign y_w  = 31'(yp_s5 >> PROD_SHIFT);
	assign z_w  = 32'(zp_s5 >> PROD_SHIFT);
	assign xs_w = x_s5 * x_s5;
	assign ys_w = y_w * y_w;
	assign zs_w = z_w * z_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_s6 <= xs_w;
			ys_s6 <= ys_w;
			zs_s6 <= zs_w;
		end
	end

	// stage 7: sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s7 <= 64'(xs_s6) + 64'(ys_s6) + zs_s6;
		end
	end

	cie94_sqrt u_sqrt_e (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s7),
		.root (root)
	);

	// round to nearest and saturate
	assign rnd_w = {1'b0, root} + (33'd1 << (SUM_FRAC - 1));
	assign res_w = 19'(rnd_w >> SUM_FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (res_w > {2'b00, DIFF_MAX}) begin
				difference_q <= DIFF_MAX;
				saturated_q  <= 1'b1;
			end else begin
				difference_q <= res_w[16:0];
				saturated_q  <= 1'b0;
			end
		end
	end

	// occupancy of the pipe and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q          <= {vld_q[BACK_DEPTH-2:0], pop};
			result_valid_q <= vld_q[BACK_DEPTH-1];
		end
	end

	assign result_valid = result_valid_q;
	assign difference   = difference_q;
	assign saturated    = saturated_q;

endmodule

`default_nettype wire

// ===== rtl/cie94_color_difference.sv =====
// CIE94 colour difference, throughput one colour pair per cycle while pair_stall is low;
// the 32-stage root pipelines and the 32-stage weight dividers set the latency,
// a 4-entry queue decouples the two halves
// a held result freezes the back pipeline; the queue then fills and raises pair_stall
// reset clears the mode to graphic arts, empties the queue and drops all results
`default_nettype none

module cie94_color_difference (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// colour pairs
	input  logic               pair_valid,
	output logic               pair_stall,
	input  logic [14:0]        first_lightness,
	input  logic signed [15:0] first_green_red,
	input  logic signed [15:0] first_blue_yellow,
	input  logic [14:0]        second_lightness,
	input  logic signed [15:0] second_green_red,
	input  logic signed [15:0] second_blue_yellow,
	// results
	output logic               result_valid,
	input  logic               result_stall,
	output logic [16:0]        difference,
	output logic               saturated
);
	import cie94_pkg::*;

	mode_t mode_q;
	logic  hit;
	logic  pop;
	logic  head_valid;
	item_t head;

	// register decode: only the mode register sits at address zero
	assign hit    = (paddr[2] == REG_MODE) && (paddr[1:0] == 2'b00);
	assign pready = 1'b1;
	assign prdata = hit ? {31'd0, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRAPHIC;
		end else if (psel && penable && pwrite && pready && hit) begin
			mode_q <= mode_t'(pwdata[0]);
		end
	end

	cie94_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.mode               (mode_q),
		.pair_valid         (pair_valid),
		.pair_stall         (pair_stall),
		.first_lightness    (first_lightness),
		.first_green_red    (first_green_red),
		.first_blue_yellow  (first_blue_yellow),
		.second_lightness   (second_lightness),
		.second_green_red   (second_green_red),
		.second_blue_yellow (second_blue_yellow),
		.pop                (pop),
		.head_valid         (head_valid),
		.head               (head)
	);

	cie94_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.difference   (difference),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire

// ===== rtl/cie94_checker.sv =====
// port-level checks for the cie94 colour difference block, bound to the top level
`default_nettype none

module cie94_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire [2:0]  paddr,
	input wire [31:0] pwdata,
	input wire [31:0] prdata,
	input wire        pair_stall,
	input wire        result_valid,
	input wire        result_stall,
	input wire [16:0] difference,
	input wire        saturated
);

	// once reset has been seen at an edge nothing is offered and requests are taken
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> (!result_valid && !pair_stall))
		else $error("result or stall during reset");

	// a clipped result always carries the maximum value
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |-> (difference == 17'h1FFFF))
		else $error("saturated flag without maximum difference");

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(difference)
			&& $stable(saturated)))
		else $error("held result changed");

	// the mode register reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr == 3'd0)) ##1 (paddr == 3'd0)
			|-> (prdata[0] == $past(pwdata[0])) && (prdata[31:1] == 31'd0))
		else $error("mode register read back wrong");

endmodule

bind cie94_color_difference cie94_checker u_cie94_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pair_stall   (pair_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.difference   (difference),
	.saturated    (saturated)
);

`default_nettype wire
